>>> rtl/core/serial_receive_line_buffer_assert.svh
// assertion macros shared by the serial receive line buffer rtl
// no dependencies; included by modules that check their own logic
`ifndef SERIAL_RECEIVE_LINE_BUFFER_ASSERT_SVH
`define SERIAL_RECEIVE_LINE_BUFFER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SRLB_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("srlb assertion failed");

// next-cycle implication, disabled during reset
`define SRLB_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("srlb assertion failed");

`endif

>>> rtl/core/srlb_pkg.sv
// shared constants and types for the serial receive line buffer
// no dependencies; used by serial_receive_line_buffer
package srlb_pkg;

  // default geometry of the line store
  localparam int LINE_LEN_DEFAULT  = 32;
  localparam int ROW_COUNT_DEFAULT = 4;

  // operation codes carried in s_tuser
  localparam logic [1:0] OP_RECEIVE = 2'd0;
  localparam logic [1:0] OP_READ    = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam logic [7:0] LINEFEED = 8'h0A;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       line_done;
    logic [1:0] done_row;
    logic       row_ready;
  } result_t;

endpackage

>>> rtl/core/srlb_ram.sv
// generic simple dual port ram, one write port, one registered read port
// no dependencies; instanced by serial_receive_line_buffer
module srlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/core/serial_receive_line_buffer.sv
// Serial receive line buffer: received bytes fill a ring of ROW_COUNT rows of LINE_LEN bytes
// in one ram; a row ends when full or on a linefeed (a leading linefeed is kept in the row
// when skip_leading_newline is 1), which sets the row's ready flag and moves to the next row.
// The next row reads back as zeros from then on through a per-row fill count, so no clearing
// pass is needed after reset or at a row change. One item is accepted every cycle unless the
// output stalls on m_tready; each gives one result via the ram read, then the output register.
// Depends on srlb_pkg, srlb_ram and serial_receive_line_buffer_assert.svh.
module serial_receive_line_buffer #(
  parameter int LINE_LEN  = srlb_pkg::LINE_LEN_DEFAULT,
  parameter int ROW_COUNT = srlb_pkg::ROW_COUNT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: skip_leading_newline
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] data_byte, [9:8] row_select, [14:10] column_select
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] out_byte, [9:8] done_row, [10] row_ready
  output logic        m_tlast    // line_done
);

  localparam int COL_W  = $clog2(LINE_LEN);
  localparam int ROW_W  = $clog2(ROW_COUNT);
  localparam int FILL_W = $clog2(LINE_LEN + 1);
  localparam int DEPTH  = ROW_COUNT * LINE_LEN;
  localparam int ADDR_W = $clog2(DEPTH);

  // control state
  logic                skip_leading_newline;
  logic [FILL_W-1:0]   row_fill [ROW_COUNT];
  logic [ROW_COUNT-1:0] ready_flags;
  logic [ROW_W-1:0]    write_row;
  logic [COL_W-1:0]    write_column;

  // pipeline state
  logic                v1;
  logic                mem_sel1;
  srlb_pkg::result_t   res1;
  logic                ov;
  srlb_pkg::result_t   ores;

  // decode
  logic              accept;
  logic              s1_move;
  logic [1:0]        op;
  logic [7:0]        in_byte;
  logic [1:0]        in_row;
  logic [4:0]        in_col;
  logic [ROW_W-1:0]  sel_idx;
  logic              sel_in_range;
  logic              end_row;
  logic [ROW_W-1:0]  next_row;
  logic [FILL_W-1:0] next_col;
  logic              read_hit;
  logic              rx_accept;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        ram_rdata;
  srlb_pkg::result_t res_next;

  assign op      = s_tuser;
  assign in_byte = s_tdata[7:0];
  assign in_row  = s_tdata[9:8];
  assign in_col  = s_tdata[14:10];

  // handshake: stage one drains into the output register, nothing taken in reset
  assign s1_move   = v1 && (!ov || m_tready);
  assign s_tready  = !rst && (!v1 || s1_move);
  assign accept    = s_tvalid && s_tready;
  assign rx_accept = accept && (op == srlb_pkg::OP_RECEIVE);

  // row end and pointer advance
  assign sel_idx      = ROW_W'(in_row);
  assign sel_in_range = int'(in_row) < ROW_COUNT;
  assign next_col     = FILL_W'(write_column) + 1'b1;
  assign end_row      = (write_column == COL_W'(LINE_LEN - 1)) ||
                        ((in_byte == srlb_pkg::LINEFEED) &&
                         ((write_column != '0) || !skip_leading_newline));
  assign next_row     = (write_row == ROW_W'(ROW_COUNT - 1)) ? '0 : write_row + 1'b1;

  // a stored byte is live only below the row's fill count
  assign read_hit = sel_in_range && (int'(in_col) < int'(row_fill[sel_idx]));
  assign wr_addr  = ADDR_W'(int'(write_row) * LINE_LEN + int'(write_column));
  assign rd_addr  = ADDR_W'(int'(sel_idx) * LINE_LEN + int'(in_col));

  srlb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (rx_accept),
    .wr_addr (wr_addr),
    .wr_data (in_byte),
    .rd_en   (accept && (op == srlb_pkg::OP_READ) && read_hit),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata)
  );

  // result fields known at accept time
  always_comb begin
    res_next = '0;
    case (op)
      srlb_pkg::OP_RECEIVE: begin
        res_next.out_byte  = in_byte;
        res_next.line_done = end_row;
        res_next.done_row  = end_row ? 2'(write_row) : 2'd0;
        res_next.row_ready = ready_flags[write_row];
      end
      srlb_pkg::OP_READ, srlb_pkg::OP_CLEAR: begin
        res_next.row_ready = sel_in_range && ready_flags[sel_idx];
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      skip_leading_newline <= 1'b1;
    end else if (cfg_we) begin
      skip_leading_newline <= cfg_wdata;
    end
  end

  // write pointer, fill counts and ready flags
  always_ff @(posedge clk) begin
    if (rst) begin
      write_row    <= '0;
      write_column <= '0;
      ready_flags  <= '0;
      for (int i = 0; i < ROW_COUNT; i++) begin
        row_fill[i] <= '0;
      end
    end else if (accept) begin
      if (op == srlb_pkg::OP_RECEIVE) begin
        row_fill[write_row] <= next_col;
        if (end_row) begin
          ready_flags[write_row] <= 1'b1;
          row_fill[next_row]     <= '0;
          write_row              <= next_row;
          write_column           <= '0;
        end else begin
          write_column <= COL_W'(next_col);
        end
      end else if ((op == srlb_pkg::OP_CLEAR) && sel_in_range) begin
        ready_flags[sel_idx] <= 1'b0;
      end
    end
  end

  // stage one: waits for ram read data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (accept) begin
      v1 <= 1'b1;
    end else if (s1_move) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res1     <= res_next;
      mem_sel1 <= (op == srlb_pkg::OP_READ) && read_hit;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (s1_move) begin
      ov <= 1'b1;
    end else if (m_tready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      ores <= '{out_byte:  (mem_sel1 ? ram_rdata : res1.out_byte),
                line_done: res1.line_done,
                done_row:  res1.done_row,
                row_ready: res1.row_ready};
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {5'b0, ores.row_ready, ores.done_row, ores.out_byte};
  assign m_tlast  = ores.line_done;

  // checks
  `include "serial_receive_line_buffer_assert.svh"

  `SRLB_ASSERT_NOW(a_col_tracks_fill, clk, rst, 1'b1, FILL_W'(write_column) == row_fill[write_row])
  `SRLB_ASSERT_NEXT(a_row_end_advances, clk, rst, rx_accept && end_row, (write_column == '0) && ready_flags[$past(write_row)])
  `SRLB_ASSERT_NEXT(a_held_read_stable, clk, rst, v1 && !s1_move, $stable(ram_rdata) && v1)
  `SRLB_ASSERT_NOW(a_new_row_empty, clk, rst, write_column == '0, row_fill[write_row] == '0)

endmodule
